@@ rtl/crle_pkg.sv @@
// Package for the cmap range lookup engine: codes, constants, record type.
// Used by every file of the block; no dependencies.
package crle_pkg;

    localparam int MaxRecords   = 256;
    localparam int RecIdxW      = 8;
    localparam int RecCntW      = 9;
    localparam int SpaceSlots   = 4;
    localparam int SlotIdxW     = 2;
    localparam int SlotCntW     = 3;
    localparam int Utf8MaxBytes = 8;

    localparam logic [20:0] SurrLo    = 21'h00D800;
    localparam logic [20:0] SurrHi    = 21'h00DFFF;
    localparam logic [20:0] ScalarMax = 21'h10FFFF;

    // actions
    localparam logic [2:0] ActClear  = 3'd0;
    localparam logic [2:0] ActSpace  = 3'd1;
    localparam logic [2:0] ActExact  = 3'd2;
    localparam logic [2:0] ActSeq    = 3'd3;
    localparam logic [2:0] ActLookup = 3'd4;

    // status codes
    localparam logic [2:0] StOk        = 3'd0;
    localparam logic [2:0] StUnsup     = 3'd1;
    localparam logic [2:0] StLimit     = 3'd2;
    localparam logic [2:0] StMalformed = 3'd3;
    localparam logic [2:0] StBadScalar = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] code_bytes;
        logic [2:0]  byte_count;
        logic [31:0] range_first;
        logic [31:0] range_last;
        logic [20:0] dest_scalar;
        logic [63:0] utf8_in;
        logic [3:0]  utf8_in_length;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] code_value;
        logic [2:0]  code_length;
        logic [63:0] utf8_out;
        logic [3:0]  utf8_out_length;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic              load;     // capture request
        logic              exec;     // perform add/clear/decode of request
        logic              slot_chk; // test codespace slot slot_idx
        logic [SlotIdxW-1:0] slot_idx;
        logic              rd;       // read record rd_idx
        logic [RecIdxW-1:0] rd_idx;
        logic              apply;    // build result from last read record
        logic              miss;     // result is unsupported
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic              is_lookup;
        logic              slot_hit;
        logic              slot_found;
        logic              covers;     // last read record covers code
        logic              key_le;     // last read key <= target
        logic              sorted;
        logic              cache_ok;
        logic [RecIdxW-1:0] cache_idx;
        logic [RecCntW-1:0] rec_count;
    } t_sts;

    function automatic logic [31:0] len_mask(input logic [2:0] len);
        case (len)
            3'd1:    len_mask = 32'h0000_00FF;
            3'd2:    len_mask = 32'h0000_FFFF;
            3'd3:    len_mask = 32'h00FF_FFFF;
            3'd0:    len_mask = 32'h0000_0000;
            default: len_mask = 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic is_surr(input logic [20:0] s);
        is_surr = (s >= SurrLo) && (s <= SurrHi);
    endfunction

endpackage

@@ rtl/crle_if.sv @@
// Valid/ready channel interfaces carrying one word of type t_req or t_rsp.
// Depends on crle_pkg for the payload types.
interface crle_req_if;
    logic             valid;
    logic             ready;
    crle_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crle_rsp_if;
    logic             valid;
    logic             ready;
    crle_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/crle_datapath.sv @@
// Datapath: codespace slots, record memory, sort tracking, result build.
// Depends on crle_pkg.
module crle_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  crle_pkg::t_req  i_req,
    input  crle_pkg::t_cmd  i_cmd,
    output crle_pkg::t_sts  o_sts,
    output crle_pkg::t_rsp  o_rsp
);
    // record memory, written at rec_count, read at one address
    logic [31:0] m_first   [crle_pkg::MaxRecords];
    logic [31:0] m_last    [crle_pkg::MaxRecords];
    logic [7:0]  m_info    [crle_pkg::MaxRecords];
    logic [63:0] m_payload [crle_pkg::MaxRecords];

    crle_pkg::t_req r_req;
    logic [31:0] r_sp_first [crle_pkg::SpaceSlots];
    logic [31:0] r_sp_last  [crle_pkg::SpaceSlots];
    logic [2:0]  r_sp_len   [crle_pkg::SpaceSlots];
    logic [crle_pkg::SlotCntW-1:0] r_sp_cnt;
    logic [crle_pkg::RecCntW-1:0]  r_rec_cnt;
    logic        r_sorted;
    logic [34:0] r_prev_key;
    logic [31:0] r_prev_last;
    logic        r_prev_valid;
    logic [crle_pkg::RecIdxW-1:0] r_cache_idx;
    logic        r_cache_valid;
    logic [31:0] r_code;
    logic [2:0]  r_len;
    logic        r_found;
    logic [31:0] r_rd_first, r_rd_last;
    logic [7:0]  r_rd_info;
    logic [63:0] r_rd_payload;
    logic [crle_pkg::RecIdxW-1:0] r_rd_idx;
    logic [20:0] r_scalar;
    crle_pkg::t_rsp r_rsp;

    // request decode
    logic [2:0]  avail;
    logic        len_ok, sp_bad, ex_bad, seq_bad_len, seq_bad_scalar, seq_bad_span;
    logic [32:0] span;
    logic [21:0] ls;
    logic [34:0] key;
    logic        unsorted_now, rec_full;
    logic [63:0] u8mask;
    logic        do_space, do_rec;
    logic [2:0]  add_st;

    always_comb begin
        key = {r_req.byte_count, r_req.range_first};
        len_ok = (r_req.byte_count >= 3'd1) && (r_req.byte_count <= 3'd4) &&
                 (r_req.range_first <= crle_pkg::len_mask(r_req.byte_count));
        sp_bad = !len_ok || (r_req.range_last > crle_pkg::len_mask(r_req.byte_count));
        ex_bad = !len_ok || (r_req.utf8_in_length > 4'(crle_pkg::Utf8MaxBytes));
        seq_bad_len = sp_bad || (r_req.range_last < r_req.range_first);
        seq_bad_scalar = (r_req.dest_scalar > crle_pkg::ScalarMax) ||
                         crle_pkg::is_surr(r_req.dest_scalar);
        span = {1'b0, r_req.range_last} - {1'b0, r_req.range_first} + 33'd1;
        ls = {1'b0, r_req.dest_scalar} + span[21:0] - 22'd1;
        seq_bad_span = (span > 33'(crle_pkg::MaxRecords)) ||
                       (ls > {1'b0, crle_pkg::ScalarMax}) ||
                       ((ls >= {1'b0, crle_pkg::SurrLo}) && (ls <= {1'b0, crle_pkg::SurrHi})) ||
                       ((r_req.dest_scalar < crle_pkg::SurrLo) &&
                        (ls >= {1'b0, crle_pkg::SurrLo}));
        rec_full = r_rec_cnt >= crle_pkg::RecCntW'(crle_pkg::MaxRecords);
        unsorted_now = r_prev_valid && ((key < r_prev_key) ||
            ((r_req.byte_count == r_prev_key[34:32]) &&
             (r_req.range_first <= r_prev_last)));
        u8mask = (r_req.utf8_in_length == 4'd0) ? 64'd0 :
                 (r_req.utf8_in_length >= 4'd8) ? '1 :
                 ~(64'hFFFF_FFFF_FFFF_FFFF >> {r_req.utf8_in_length[2:0], 3'b000});
        do_space = 1'b0;
        do_rec = 1'b0;
        add_st = crle_pkg::StOk;
        case (r_req.action)
            crle_pkg::ActClear: add_st = crle_pkg::StOk;
            crle_pkg::ActSpace: begin
                if (sp_bad) add_st = crle_pkg::StMalformed;
                else if (r_req.range_last < r_req.range_first ||
                         r_sp_cnt >= crle_pkg::SlotCntW'(crle_pkg::SpaceSlots))
                    add_st = crle_pkg::StLimit;
                else do_space = 1'b1;
            end
            crle_pkg::ActExact: begin
                if (ex_bad) add_st = crle_pkg::StMalformed;
                else if (rec_full) add_st = crle_pkg::StLimit;
                else do_rec = 1'b1;
            end
            crle_pkg::ActSeq: begin
                if (seq_bad_len) add_st = crle_pkg::StMalformed;
                else if (seq_bad_scalar) add_st = crle_pkg::StBadScalar;
                else if (seq_bad_span) add_st = crle_pkg::StMalformed;
                else if (rec_full) add_st = crle_pkg::StLimit;
                else do_rec = 1'b1;
            end
            crle_pkg::ActLookup: add_st = crle_pkg::StOk;
            default: add_st = crle_pkg::StMalformed;
        endcase
    end

    // slot compare
    logic [2:0]  sl;
    logic [31:0] sv;
    logic        slot_hit;
    always_comb begin
        avail = (r_req.byte_count > 3'd4) ? 3'd4 : r_req.byte_count;
        sl = r_sp_len[i_cmd.slot_idx];
        case (sl)
            3'd1:    sv = {24'd0, r_req.code_bytes[31:24]};
            3'd2:    sv = {16'd0, r_req.code_bytes[31:16]};
            3'd3:    sv = {8'd0, r_req.code_bytes[31:8]};
            default: sv = r_req.code_bytes;
        endcase
        slot_hit = (sl != 3'd0) && (sl <= avail) && (sv >= r_sp_first[i_cmd.slot_idx]) &&
                   (sv <= r_sp_last[i_cmd.slot_idx]);
    end

    // control/table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.exec && r_req.action == crle_pkg::ActClear)) begin
            for (int i = 0; i < crle_pkg::SpaceSlots; i++) begin
                r_sp_first[i] <= '0;
                r_sp_last[i]  <= '0;
                r_sp_len[i]   <= '0;
            end
            r_sp_cnt <= '0;
            r_rec_cnt <= '0;
            r_sorted <= 1'b1;
            r_prev_key <= '0;
            r_prev_last <= '0;
            r_prev_valid <= 1'b0;
            r_cache_idx <= '0;
            r_cache_valid <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) r_found <= 1'b0;
            if (i_cmd.exec && do_space) begin
                r_sp_first[r_sp_cnt[crle_pkg::SlotIdxW-1:0]] <= r_req.range_first;
                r_sp_last[r_sp_cnt[crle_pkg::SlotIdxW-1:0]]  <= r_req.range_last;
                r_sp_len[r_sp_cnt[crle_pkg::SlotIdxW-1:0]]   <= r_req.byte_count;
                r_sp_cnt <= r_sp_cnt + 1'b1;
            end
            if (i_cmd.exec && do_rec) begin
                if (unsorted_now) r_sorted <= 1'b0;
                r_prev_key <= key;
                r_prev_last <= (r_req.action == crle_pkg::ActSeq) ?
                               r_req.range_last : r_req.range_first;
                r_prev_valid <= 1'b1;
                r_rec_cnt <= r_rec_cnt + 1'b1;
            end
            if (i_cmd.slot_chk && slot_hit && !r_found) r_found <= 1'b1;
            if (i_cmd.apply && r_rd_info[0] == 1'b0 ||
                i_cmd.apply && r_rd_info[0] && !(r_scalar > crle_pkg::ScalarMax ||
                                                 crle_pkg::is_surr(r_scalar))) begin
                r_cache_idx <= r_rd_idx;
                r_cache_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.slot_chk && slot_hit && !r_found) begin
            r_code <= sv;
            r_len <= sl;
        end
        if (i_cmd.exec && do_rec) begin
            m_first[r_rec_cnt[crle_pkg::RecIdxW-1:0]] <= r_req.range_first;
            m_last[r_rec_cnt[crle_pkg::RecIdxW-1:0]] <=
                (r_req.action == crle_pkg::ActSeq) ? r_req.range_last : r_req.range_first;
            m_info[r_rec_cnt[crle_pkg::RecIdxW-1:0]] <=
                (r_req.action == crle_pkg::ActSeq) ? {4'd0, r_req.byte_count, 1'b1}
                                                   : {r_req.utf8_in_length, r_req.byte_count, 1'b0};
            m_payload[r_rec_cnt[crle_pkg::RecIdxW-1:0]] <=
                (r_req.action == crle_pkg::ActSeq) ? {43'd0, r_req.dest_scalar}
                                                   : (r_req.utf8_in & u8mask);
        end
        if (i_cmd.rd) begin
            r_rd_first   <= m_first[i_cmd.rd_idx];
            r_rd_last    <= m_last[i_cmd.rd_idx];
            r_rd_info    <= m_info[i_cmd.rd_idx];
            r_rd_payload <= m_payload[i_cmd.rd_idx];
            r_rd_idx     <= i_cmd.rd_idx;
        end
    end

    // scalar offset, registered from the read record
    logic covers;
    always_comb begin
        covers = (r_rd_info[3:1] == r_len) && (r_code >= r_rd_first) &&
                 (r_code <= r_rd_last);
    end
    always_ff @(posedge i_clk) begin
        r_scalar <= r_rd_payload[20:0] + 21'(r_code - r_rd_first);
    end

    // UTF-8 encoding of the scalar
    logic [63:0] enc;
    logic [3:0]  enc_n;
    logic        bad_s;
    always_comb begin
        bad_s = (r_scalar > crle_pkg::ScalarMax) || crle_pkg::is_surr(r_scalar);
        if (r_scalar < 21'h80) begin
            enc = {1'b0, r_scalar[6:0], 56'd0};
            enc_n = 4'd1;
        end else if (r_scalar < 21'h800) begin
            enc = {3'b110, r_scalar[10:6], 2'b10, r_scalar[5:0], 48'd0};
            enc_n = 4'd2;
        end else if (r_scalar < 21'h10000) begin
            enc = {4'b1110, r_scalar[15:12], 2'b10, r_scalar[11:6], 2'b10,
                   r_scalar[5:0], 40'd0};
            enc_n = 4'd3;
        end else begin
            enc = {5'b11110, r_scalar[20:18], 2'b10, r_scalar[17:12], 2'b10,
                   r_scalar[11:6], 2'b10, r_scalar[5:0], 32'd0};
            enc_n = 4'd4;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_rsp <= '{status: add_st, default: '0};
        if (i_cmd.miss) r_rsp <= '{status: crle_pkg::StUnsup, default: '0};
        if (i_cmd.apply) begin
            if (r_rd_info[0] && bad_s) begin
                r_rsp <= '{status: crle_pkg::StBadScalar, default: '0};
            end else begin
                r_rsp.status <= crle_pkg::StOk;
                r_rsp.code_value <= r_code;
                r_rsp.code_length <= r_len;
                r_rsp.utf8_out <= r_rd_info[0] ? enc : r_rd_payload;
                r_rsp.utf8_out_length <= r_rd_info[0] ? enc_n : r_rd_info[7:4];
            end
        end
    end

    assign o_rsp = r_rsp;
    assign o_sts = '{
        is_lookup:  (r_req.action == crle_pkg::ActLookup),
        slot_hit:   slot_hit,
        slot_found: r_found,
        covers:     covers,
        key_le:     ({r_rd_info[3:1], r_rd_first} <= {r_len, r_code}),
        sorted:     r_sorted,
        cache_ok:   r_cache_valid && ({1'b0, r_cache_idx} < r_rec_cnt),
        cache_idx:  r_cache_idx,
        rec_count:  r_rec_cnt
    };

    // a record is never stored past the table end
    a_rec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_cnt <= crle_pkg::RecCntW'(crle_pkg::MaxRecords))
        else $error("record count overflow");
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp_cnt <= crle_pkg::SlotCntW'(crle_pkg::SpaceSlots))
        else $error("slot count overflow");
    a_sort_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_sorted && !(i_cmd.exec && r_req.action == crle_pkg::ActClear)) |=> !r_sorted)
        else $error("sorted flag set without clear");
endmodule

@@ rtl/crle_ctrl.sv @@
// Controller: sequences codespace scan, cache probe, binary or linear search.
// Depends on crle_pkg.
module crle_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  crle_pkg::t_sts  i_sts,
    output crle_pkg::t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_SLOT  = 4'd2;
    localparam logic [3:0] S_CRD   = 4'd3;
    localparam logic [3:0] S_CCHK  = 4'd4;
    localparam logic [3:0] S_BRD   = 4'd5;
    localparam logic [3:0] S_BCHK  = 4'd6;
    localparam logic [3:0] S_FRD   = 4'd7;
    localparam logic [3:0] S_LRD   = 4'd8;
    localparam logic [3:0] S_LCHK  = 4'd9;
    localparam logic [3:0] S_WAIT  = 4'd10;
    localparam logic [3:0] S_APPLY = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] r_state, n_state;
    logic [crle_pkg::SlotCntW-1:0] r_slot, n_slot;
    logic [crle_pkg::RecCntW-1:0]  r_lo, n_lo, r_hi, n_hi, r_idx, n_idx;
    logic [crle_pkg::RecCntW-1:0]  mid;

    always_comb begin
        n_state = r_state;
        n_slot = r_slot;
        n_lo = r_lo;
        n_hi = r_hi;
        n_idx = r_idx;
        o_cmd = '0;
        mid = r_lo + ((r_hi - r_lo) >> 1);
        o_in_ready = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_slot = '0;
                n_state = i_sts.is_lookup ? S_SLOT : S_OUT;
            end
            S_SLOT: begin
                o_cmd.slot_chk = 1'b1;
                o_cmd.slot_idx = r_slot[crle_pkg::SlotIdxW-1:0];
                if (i_sts.slot_hit || i_sts.slot_found) n_state = S_CRD;
                else if (r_slot == crle_pkg::SlotCntW'(crle_pkg::SpaceSlots - 1)) begin
                    o_cmd.miss = 1'b1;
                    n_state = S_OUT;
                end else n_slot = r_slot + 1'b1;
            end
            S_CRD: begin
                if (i_sts.cache_ok) begin
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_idx = i_sts.cache_idx;
                    n_state = S_CCHK;
                end else n_state = S_CCHK;
            end
            S_CCHK: begin
                if (i_sts.cache_ok && i_sts.covers) n_state = S_WAIT;
                else begin
                    n_lo = '0;
                    n_hi = i_sts.rec_count;
                    n_idx = '0;
                    n_state = i_sts.sorted ? S_BRD : S_LRD;
                end
            end
            S_BRD: begin
                if (r_lo < r_hi) begin
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_idx = mid[crle_pkg::RecIdxW-1:0];
                    n_idx = mid;
                    n_state = S_BCHK;
                end else if (r_lo == '0) begin
                    o_cmd.miss = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_idx = 8'(r_lo - 1'b1);
                    n_state = S_FRD;
                end
            end
            S_BCHK: begin
                if (i_sts.key_le) n_lo = r_idx + 1'b1;
                else n_hi = r_idx;
                n_state = S_BRD;
            end
            S_FRD: begin
                if (i_sts.covers) n_state = S_WAIT;
                else begin
                    o_cmd.miss = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_LRD: begin
                if (r_idx < i_sts.rec_count) begin
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_idx = r_idx[crle_pkg::RecIdxW-1:0];
                    n_state = S_LCHK;
                end else begin
                    o_cmd.miss = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_LCHK: begin
                if (i_sts.covers) n_state = S_WAIT;
                else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_LRD;
                end
            end
            S_WAIT: n_state = S_APPLY;  // scalar offset settles
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot <= '0;
            r_lo <= '0;
            r_hi <= '0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_slot <= n_slot;
            r_lo <= n_lo;
            r_hi <= n_hi;
            r_idx <= n_idx;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.exec, o_cmd.miss, o_cmd.apply}))
        else $error("conflicting commands");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.apply || o_cmd.miss) |=> o_out_valid)
        else $error("result not presented");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_in_ready)
        else $error("accepted while busy");
endmodule

@@ rtl/cmap_range_lookup_engine_core.sv @@
// Top level of the cmap range lookup engine: controller plus datapath.
// Depends on crle_pkg, crle_if, crle_ctrl, crle_datapath.
//
// Usage: requests arrive as words on s_req (valid/ready); each produces one
// result word on m_rsp. One word is in work at a time.
// Clear and adds pass through accept, execute, then the result word.
// A lookup passes through accept and execute, tests codespace slots one by one
// (up to 4), then reads and checks the cached record; a cache hit then waits for
// the scalar offset and applies the record.
// On a miss a sorted table is binary searched, one read and one check per step
// (up to 9 steps for 256 records), then the final record is read, checked and
// applied; an unsorted table is scanned linearly, one read and one check per record.
// The record memory has a single read port, so each step reads one record.
// Reset (i_rst_n low, synchronous) empties the codespace and record
// tables; action clear does the same. Record memory is not cleared: only
// entries below the record count are ever read.
// If the receiver stalls, the result word holds on m_rsp and no new
// request is accepted until it is taken.
module cmap_range_lookup_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crle_req_if.sink    s_req,
    crle_rsp_if.source  m_rsp
);
    crle_pkg::t_cmd cmd;
    crle_pkg::t_sts sts;

    crle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_req.valid),
        .o_in_ready  (s_req.ready),
        .o_out_valid (m_rsp.valid),
        .i_out_ready (m_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    crle_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req.data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (m_rsp.data)
    );
endmodule

@@ test/crle_checker.sv @@
// Checker for the cmap range lookup engine: watches request and result words,
// predicts each result from its own copy of the tables and compares field by field.
// Depends on crle_pkg and crle_if.
module crle_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crle_req_if        req,
    crle_rsp_if        rsp,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // predictor state
    logic [31:0] sp_first [crle_pkg::SpaceSlots];
    logic [31:0] sp_last  [crle_pkg::SpaceSlots];
    logic [2:0]  sp_len   [crle_pkg::SpaceSlots];
    int          sp_count;
    logic [31:0] tb_first [crle_pkg::MaxRecords];
    logic [31:0] tb_last  [crle_pkg::MaxRecords];
    logic        tb_seq   [crle_pkg::MaxRecords];
    logic [2:0]  tb_len   [crle_pkg::MaxRecords];
    logic [3:0]  tb_ulen  [crle_pkg::MaxRecords];
    logic [63:0] tb_data  [crle_pkg::MaxRecords];
    int          tb_count;
    logic        tb_sorted;
    logic [34:0] last_key;
    logic [31:0] last_end;
    logic        last_ok;
    int          hot_idx;
    logic        hot_ok;

    crle_pkg::t_rsp expected_rsp_q [$];

    function automatic logic [31:0] mask_of(input int n);
        return n >= 4 ? 32'hFFFF_FFFF : 32'((64'd1 << (8 * n)) - 1);
    endfunction

    function automatic void wipe_tables();
        for (int k = 0; k < crle_pkg::SpaceSlots; k++) begin
            sp_first[k] = '0; sp_last[k] = '0; sp_len[k] = '0;
        end
        sp_count = 0; tb_count = 0; tb_sorted = 1'b1;
        last_key = '0; last_end = '0; last_ok = 1'b0;
        hot_idx = 0; hot_ok = 1'b0;
    endfunction

    function automatic logic [2:0] store_record(input logic [31:0] f, input logic [31:0] l,
            input logic [2:0] n, input logic s, input logic [3:0] ul, input logic [63:0] p);
        logic [34:0] k;
        k = {n, f};
        if (tb_count >= crle_pkg::MaxRecords) return crle_pkg::StLimit;
        if (last_ok && (k < last_key || (n == last_key[34:32] && f <= last_end)))
            tb_sorted = 1'b0;
        tb_first[tb_count] = f; tb_last[tb_count] = l; tb_len[tb_count] = n;
        tb_seq[tb_count] = s; tb_ulen[tb_count] = ul; tb_data[tb_count] = p;
        last_key = k; last_end = l; last_ok = 1'b1;
        tb_count++;
        return crle_pkg::StOk;
    endfunction

    function automatic int utf8_of(input logic [31:0] s, output logic [63:0] o);
        logic [63:0] v;
        int n;
        o = '0;
        if (s > 32'h10FFFF || (s >= 32'hD800 && s <= 32'hDFFF)) return 0;
        if (s < 32'h80) begin v = 64'(s); n = 1; end
        else if (s < 32'h800) begin
            v = {48'd0, 3'b110, s[10:6], 2'b10, s[5:0]}; n = 2;
        end else if (s < 32'h10000) begin
            v = {40'd0, 4'hE, s[15:12], 2'b10, s[11:6], 2'b10, s[5:0]}; n = 3;
        end else begin
            v = {32'd0, 5'b11110, s[20:18], 2'b10, s[17:12], 2'b10, s[11:6], 2'b10, s[5:0]};
            n = 4;
        end
        o = v << (64 - 8 * n);
        return n;
    endfunction

    function automatic logic covers(input int i, input logic [31:0] c, input logic [2:0] n);
        return tb_len[i] == n && c >= tb_first[i] && c <= tb_last[i];
    endfunction

    function automatic logic [2:0] use_record(input int i, input logic [31:0] c,
            input logic [2:0] n, inout crle_pkg::t_rsp r);
        logic [63:0] u;
        int m;
        if (!covers(i, c, n)) return crle_pkg::StUnsup;
        if (tb_seq[i]) begin
            m = utf8_of(tb_data[i][31:0] + (c - tb_first[i]), u);
            if (m == 0) return crle_pkg::StBadScalar;
            r.utf8_out = u; r.utf8_out_length = 4'(m);
        end else begin
            r.utf8_out = tb_data[i]; r.utf8_out_length = tb_ulen[i];
        end
        r.code_value = c; r.code_length = n;
        hot_idx = i; hot_ok = 1'b1;
        return crle_pkg::StOk;
    endfunction

    function automatic logic [2:0] find_code(input logic [31:0] b, input logic [2:0] avail,
            inout crle_pkg::t_rsp r);
        logic [31:0] c;
        logic [2:0] n;
        logic hit;
        int lo, hi, mid, a;
        c = '0; n = '0; hit = 1'b0;
        a = avail > 4 ? 4 : avail;
        for (int k = 0; k < crle_pkg::SpaceSlots && !hit; k++) begin
            if (sp_len[k] != 0 && sp_len[k] <= a) begin
                c = b >> (32 - 8 * sp_len[k]);
                if (c >= sp_first[k] && c <= sp_last[k]) begin
                    n = sp_len[k]; hit = 1'b1;
                end
            end
        end
        if (!hit) return crle_pkg::StUnsup;
        if (hot_ok && hot_idx < tb_count && covers(hot_idx, c, n))
            return use_record(hot_idx, c, n, r);
        if (tb_sorted) begin
            lo = 0; hi = tb_count;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if ({tb_len[mid], tb_first[mid]} <= {n, c}) lo = mid + 1;
                else hi = mid;
            end
            if (lo == 0) return crle_pkg::StUnsup;
            return use_record(lo - 1, c, n, r);
        end
        for (int i = 0; i < tb_count; i++)
            if (covers(i, c, n)) return use_record(i, c, n, r);
        return crle_pkg::StUnsup;
    endfunction

    function automatic crle_pkg::t_rsp predict_result(input crle_pkg::t_req q);
        crle_pkg::t_rsp r;
        logic fit;
        logic [63:0] m, span, ls;
        r = '0;
        fit = q.byte_count >= 1 && q.byte_count <= 4 && q.range_first <= mask_of(q.byte_count);
        case (q.action)
            crle_pkg::ActClear: wipe_tables();
            crle_pkg::ActSpace: begin
                if (!fit || q.range_last > mask_of(q.byte_count))
                    r.status = crle_pkg::StMalformed;
                else if (q.range_last < q.range_first || sp_count >= crle_pkg::SpaceSlots)
                    r.status = crle_pkg::StLimit;
                else begin
                    sp_first[sp_count] = q.range_first; sp_last[sp_count] = q.range_last;
                    sp_len[sp_count] = q.byte_count; sp_count++;
                end
            end
            crle_pkg::ActExact: begin
                if (!fit || q.utf8_in_length > crle_pkg::Utf8MaxBytes)
                    r.status = crle_pkg::StMalformed;
                else begin
                    m = q.utf8_in_length == 0 ? 64'd0 : ~(~64'd0 >> (8 * q.utf8_in_length));
                    r.status = store_record(q.range_first, q.range_first, q.byte_count, 1'b0,
                                            q.utf8_in_length, q.utf8_in & m);
                end
            end
            crle_pkg::ActSeq: begin
                if (!fit || q.range_last > mask_of(q.byte_count) || q.range_last < q.range_first)
                    r.status = crle_pkg::StMalformed;
                else if (q.dest_scalar > crle_pkg::ScalarMax || crle_pkg::is_surr(q.dest_scalar))
                    r.status = crle_pkg::StBadScalar;
                else begin
                    span = 64'(q.range_last) - 64'(q.range_first) + 1;
                    ls = 64'(q.dest_scalar) + span - 1;
                    if (span > crle_pkg::MaxRecords || ls > 64'(crle_pkg::ScalarMax)
                        || (ls >= 64'(crle_pkg::SurrLo) && ls <= 64'(crle_pkg::SurrHi))
                        || (q.dest_scalar < crle_pkg::SurrLo && ls >= 64'(crle_pkg::SurrLo)))
                        r.status = crle_pkg::StMalformed;
                    else
                        r.status = store_record(q.range_first, q.range_last, q.byte_count,
                                                1'b1, 4'd0, 64'(q.dest_scalar));
                end
            end
            crle_pkg::ActLookup: begin
                r.status = find_code(q.code_bytes, q.byte_count, r);
                if (r.status != crle_pkg::StOk) r = '{status: r.status, default: '0};
            end
            default: r.status = crle_pkg::StMalformed;
        endcase
        return r;
    endfunction

    assign o_pending = expected_rsp_q.size();

    // predict on each accepted request word, compare each accepted result word
    always @(posedge i_clk) begin
        crle_pkg::t_rsp e, a;
        if (!i_rst_n) begin
            wipe_tables();
            expected_rsp_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                a = rsp.data;
                o_results <= o_results + 1;
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, a);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_rsp_q.pop_front();
                    if (a.status !== e.status || a.code_value !== e.code_value
                        || a.code_length !== e.code_length || a.utf8_out !== e.utf8_out
                        || a.utf8_out_length !== e.utf8_out_length) begin
                        $display("%0t: mismatch expected %p actual %p", $realtime, e, a);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_rsp_q.push_back(predict_result(req.data));
        end
    end
endmodule

@@ test/cmap_range_lookup_engine_core_tb.sv @@
// Top of the testbench for the cmap range lookup engine: clock, reset, stimulus, verdict.
// Depends on crle_pkg, crle_if, crle_checker and the block itself.
module cmap_range_lookup_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk, rst_n;
    int   errors, pending, results;
    int   sent;
    logic hold_rx;
    logic pause_tx;

    crle_req_if req ();
    crle_rsp_if rsp ();

    cmap_range_lookup_engine_core u_dut (.i_clk(clk), .i_rst_n(rst_n), .s_req(req), .m_rsp(rsp));
    crle_checker u_chk (.i_clk(clk), .i_rst_n(rst_n), .req(req), .rsp(rsp),
                        .o_errors(errors), .o_pending(pending), .o_results(results));

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // code bytes seeded from a codespace-like pattern
    function automatic logic [31:0] pick_code(input int n);
        logic [31:0] v;
        v = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40);
        if ($urandom_range(0, 5) == 0) v = n >= 4 ? 32'hFFFF_FFFF : (32'd1 << (8 * n)) - 1;
        return n >= 4 ? v : v & ((32'd1 << (8 * n)) - 1);
    endfunction

    function automatic crle_pkg::t_req rand_word();
        crle_pkg::t_req q;
        int n, r;
        logic [31:0] f;
        q = '0;
        q.code_bytes = $urandom; q.range_first = $urandom; q.range_last = $urandom;
        q.dest_scalar = 21'($urandom); q.utf8_in = {$urandom, $urandom};
        q.utf8_in_length = 4'($urandom); q.byte_count = 3'($urandom);
        q.action = 3'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8) return q;                         // pure noise, any action
        n = $urandom_range(1, 4);
        q.byte_count = 3'(n);
        f = pick_code(n);
        if (r < 10) q.action = crle_pkg::ActClear;
        else if (r < 18) begin
            q.action = crle_pkg::ActSpace; q.range_first = f;
            q.range_last = f + $urandom_range(0, 60);
            if (n < 4 && q.range_last > (32'd1 << (8 * n)) - 1)
                q.range_last = (32'd1 << (8 * n)) - 1;
        end else if (r < 35) begin
            q.action = crle_pkg::ActExact; q.range_first = f;
            q.utf8_in_length = 4'($urandom_range(0, 9));
        end else if (r < 50) begin
            q.action = crle_pkg::ActSeq; q.range_first = f;
            q.range_last = f + $urandom_range(0, $urandom_range(0, 3) == 0 ? 300 : 20);
            q.dest_scalar = $urandom_range(0, 1) ? 21'($urandom_range(0, 32'h10FFFF))
                                                 : 21'($urandom_range(32'hD7F0, 32'hE010));
        end else begin
            q.action = crle_pkg::ActLookup;
            q.code_bytes = $urandom_range(0, 1) ? 32'({pick_code(n), 32'h0} >> (8 * n))
                                                : $urandom;
            q.code_bytes = $urandom_range(0, 1) ? q.code_bytes << (8 * (4 - n)) : q.code_bytes;
            q.byte_count = $urandom_range(0, 9) == 0 ? 3'($urandom) : 3'($urandom_range(n, 4));
        end
        return q;
    endfunction

    task automatic send_word(input crle_pkg::t_req q);
        req.valid <= 1'b1;
        req.data  <= q;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic drop_valid();
        req.valid <= 1'b0;
    endtask

    function automatic crle_pkg::t_req mk(input logic [2:0] a, input logic [2:0] n,
            input logic [31:0] f, input logic [31:0] l, input logic [20:0] d,
            input logic [31:0] b);
        crle_pkg::t_req q;
        q = '0;
        q.action = a; q.byte_count = n; q.range_first = f; q.range_last = l;
        q.dest_scalar = d; q.code_bytes = b;
        return q;
    endfunction

    task automatic drain();
        drop_valid();
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    // receiver: own stall pattern, plus a long hold when asked
    initial begin
        int mode;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            mode = (results / 300) % 3;
            if (hold_rx) rsp.ready <= 1'b0;
            else if (mode == 0) rsp.ready <= 1'b1;
            else if (mode == 1) rsp.ready <= $urandom_range(0, 3) != 0;
            else rsp.ready <= $urandom_range(0, 2) == 0;
        end
    end

    initial begin
        #60ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        crle_pkg::t_req q;
        int burst;
        sent = 0; hold_rx = 1'b0; pause_tx = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: codespaces, exact and sequential records, lookups, errors
        send_word(mk(crle_pkg::ActLookup, 3'd4, 0, 0, 0, 32'h0));              // no codespace
        send_word(mk(crle_pkg::ActSpace, 3'd1, 8'h00, 8'h7F, 0, 0));
        send_word(mk(crle_pkg::ActSpace, 3'd2, 16'h8000, 16'hFFFF, 0, 0));
        send_word(mk(crle_pkg::ActSpace, 3'd4, 32'h0, 32'hFFFF_FFFF, 0, 0));
        send_word(mk(crle_pkg::ActSpace, 3'd1, 8'h10, 8'h05, 0, 0));           // reversed
        send_word(mk(crle_pkg::ActSpace, 3'd3, 0, 24'hFFFFFF, 0, 0));
        send_word(mk(crle_pkg::ActSpace, 3'd1, 0, 1, 0, 0));                   // slots full
        send_word(mk(crle_pkg::ActSpace, 3'd0, 0, 0, 0, 0));                   // bad length
        send_word(mk(crle_pkg::ActSpace, 3'd5, 0, 0, 0, 0));
        send_word(mk(crle_pkg::ActSpace, 3'd1, 32'h100, 32'h100, 0, 0));       // does not fit
        q = mk(crle_pkg::ActExact, 3'd1, 8'h41, 0, 0, 0);
        q.utf8_in = 64'hFFFF_FFFF_FFFF_FFFF; q.utf8_in_length = 4'd3;
        send_word(q);
        q.utf8_in_length = 4'd9; send_word(q);                       // UTF-8 too long
        q.utf8_in_length = 4'd15; send_word(q);
        q.range_first = 8'h42; q.utf8_in_length = 4'd8; send_word(q);
        send_word(mk(crle_pkg::ActSeq, 3'd2, 16'h8000, 16'h80FF, 21'h7F, 0));
        send_word(mk(crle_pkg::ActSeq, 3'd2, 16'h9000, 16'h9010, 21'h1FFFFF, 0)); // bad scalar
        send_word(mk(crle_pkg::ActSeq, 3'd2, 16'h9000, 16'h9010, 21'h00D800, 0)); // surrogate
        send_word(mk(crle_pkg::ActSeq, 3'd2, 16'hA000, 16'hA010, 21'h00D7F8, 0)); // crosses
        send_word(mk(crle_pkg::ActSeq, 3'd2, 16'hA000, 16'hA100, 21'h100, 0));    // long span
        send_word(mk(crle_pkg::ActSeq, 3'd2, 16'hB000, 16'hB00F, 21'h10FFF8, 0)); // past max
        send_word(mk(crle_pkg::ActSeq, 3'd4, 32'hFFFF_FF00, 32'hFFFF_FFFF, 21'h10FF00, 0));
        send_word(mk(crle_pkg::ActLookup, 3'd1, 0, 0, 0, 32'h4100_0000));
        send_word(mk(crle_pkg::ActLookup, 3'd7, 0, 0, 0, 32'h8042_0000));
        send_word(mk(crle_pkg::ActLookup, 3'd0, 0, 0, 0, 32'h4100_0000));
        send_word(mk(3'd6, 3'd1, 0, 0, 0, 0));                       // unknown action
        drain();

        // random phase: bursts and gaps; long receiver holds while sent is 600 to 700, one full drain
        while (sent < 1850) begin
            burst = $urandom_range(1, 40);
            repeat (burst) send_word(rand_word());
            if (sent > 600 && sent < 700 && !hold_rx) begin
                drop_valid();
                fork
                    begin hold_rx = 1'b1; repeat (300) @(negedge clk); hold_rx = 1'b0; end
                    begin repeat (5) send_word(rand_word()); drop_valid(); end
                join
            end
            if (sent > 1200 && !pause_tx) begin
                pause_tx = 1'b1;
                drain();
            end
            drop_valid();
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 20)) @(negedge clk);
        end
        drain();
        repeat (600) @(negedge clk);
        $display("Ran %0d request words and checked %0d results", sent, results);
        $display("Covered codespace, exact, sequential, lookup and clear under stalls");
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
